// ===== sv/acpu_pkg.sv =====
// acpu_pkg: opcodes, status codes, flag layout and controller/datapath
// command and status structures for the accumulator processor.
// No dependencies.
package acpu_pkg;

    localparam int IO_DEPTH = 32;
    localparam int IO_AW    = 5;

    localparam logic [7:0] OP_WM   = 8'h01;
    localparam logic [7:0] OP_RM   = 8'h02;
    localparam logic [7:0] OP_WIO  = 8'h03;
    localparam logic [7:0] OP_RIO  = 8'h04;
    localparam logic [7:0] OP_WB   = 8'h06;
    localparam logic [7:0] OP_WIB  = 8'h07;
    localparam logic [7:0] OP_WACC = 8'h09;
    localparam logic [7:0] OP_RACC = 8'h0B;
    localparam logic [7:0] OP_SWAP = 8'h0C;
    localparam logic [7:0] OP_BR   = 8'h10;
    localparam logic [7:0] OP_BRLT = 8'h11;
    localparam logic [7:0] OP_BRGT = 8'h12;
    localparam logic [7:0] OP_BRNE = 8'h13;
    localparam logic [7:0] OP_BRE  = 8'h14;
    localparam logic [7:0] OP_SHR  = 8'h15;
    localparam logic [7:0] OP_SHL  = 8'h16;
    localparam logic [7:0] OP_XOR  = 8'h17;
    localparam logic [7:0] OP_NOT  = 8'h18;
    localparam logic [7:0] OP_OR   = 8'h19;
    localparam logic [7:0] OP_AND  = 8'h1A;
    localparam logic [7:0] OP_MUL  = 8'h1B;
    localparam logic [7:0] OP_SUB  = 8'h1D;
    localparam logic [7:0] OP_ADD  = 8'h1E;
    localparam logic [7:0] OP_EOP  = 8'h1F;

    localparam logic [2:0] ST_LOADED  = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_END     = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam int F_ZERO  = 0;
    localparam int F_CARRY = 1;
    localparam int F_SIGN  = 6;
    localparam int F_OVER  = 7;

    localparam logic [IO_AW-1:0] IO_MIRROR = 5'h1F;
    localparam logic [15:0] IO_LATCH_TOP = 16'h000F;
    localparam logic [15:0] IO_BUF_LO    = 16'h0010;
    localparam logic [15:0] IO_BUF_HI    = 16'h001F;

    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic fetch;    // read memory at pc, pc++
        logic cap_op;
        logic cap_lo;
        logic cap_hi;
        logic exec;
        logic mem_done; // RM read data back
        logic mul_step;
        logic load_out;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic [7:0] fetch_data;
        logic [7:0] op;
        logic       halted;
        logic       mul_last;
        logic       clr_last;
    } sts_t;

    function automatic logic [7:0] flags_of(input logic [17:0] r);
        logic [7:0] f;
        f          = 8'd0;
        f[F_ZERO]  = (r[7:0] == 8'd0);
        f[F_CARRY] = !r[17] && (|r[16:8]);
        f[F_SIGN]  = r[7];
        f[F_OVER]  = r[7] && r[17];
        return f;
    endfunction

    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ===== sv/acpu_dp.sv =====
// acpu_dp: datapath of the accumulator processor - registers, ALU, Booth
// multiplier, main memory with clearing sweep, I/O store, result register.
// Depends on acpu_pkg.
module acpu_dp #(
    parameter int MEM_DEPTH = 2048
) (
    input  logic           clk,
    input  logic           rst_n,
    input  acpu_pkg::cmd_t cmd,
    output acpu_pkg::sts_t sts,
    input  logic           in_command,
    input  logic [10:0]    in_load_address,
    input  logic [7:0]     in_load_byte,
    output logic [63:0]    out_data
);
    import acpu_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [15:0] pc_reg, mar_reg, opw_reg;
    logic [17:0] acc_reg;
    logic [7:0]  mbr_reg, iobr_reg, bus_latch_reg, flags_reg, op_reg;
    logic        halted_reg;
    logic [2:0]  status_reg;
    logic        dw_reg;
    logic [7:0]  dv_reg;
    logic [7:0]  io_reg [IO_DEPTH];

    logic [7:0]  ma_reg, mq_reg, mm_reg;
    logic        qm1_reg;
    logic [2:0]  mcnt_reg;

    logic [63:0] out_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;
    logic [17:0]   op1e, op2e, alu_r, cmp_r, mul_r;
    logic [7:0]    cmp_f, bsum, ma_next, mq_next;
    logic          take;
    logic          io_buf_hit;

    // memory write port: clearing sweep, load transfer, WM
    always_comb
    begin
        we    = 1'b0;
        waddr = clr_addr_reg;
        wdata = 8'd0;
        if (cmd.clear)
        begin
            we = 1'b1;
        end
        else if (cmd.accept && !in_command)
        begin
            we    = 1'b1;
            waddr = AW'(in_load_address);
            wdata = in_load_byte;
        end
        else if (cmd.exec && op_reg == OP_WM)
        begin
            we    = 1'b1;
            waddr = opw_reg[AW-1:0];
            wdata = mbr_reg;
        end
        raddr = cmd.fetch ? pc_reg[AW-1:0] : opw_reg[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        op1e = {10'd0, acc_reg[7:0]};
        op2e = {10'd0, bus_latch_reg};
        unique case (op_reg)
            OP_ADD:  alu_r = op1e + op2e;
            OP_SUB:  alu_r = op1e - op2e;
            OP_AND:  alu_r = op1e & op2e;
            OP_OR:   alu_r = op1e | op2e;
            OP_XOR:  alu_r = op1e ^ op2e;
            OP_NOT:  alu_r = ~op1e;
            OP_SHL:  alu_r = {op1e[16:0], 1'b0};
            OP_SHR:  alu_r = {1'b0, op1e[17:1]};
            default: alu_r = 18'd0;
        endcase
        cmp_r = acc_reg - {10'd0, mbr_reg};
        cmp_f = flags_of(cmp_r);
        unique case (op_reg)
            OP_BRE:  take = cmp_f[F_ZERO];
            OP_BRNE: take = !cmp_f[F_ZERO];
            OP_BRGT: take = !cmp_f[F_ZERO] && !cmp_f[F_SIGN];
            OP_BRLT: take = cmp_f[F_SIGN] && !cmp_f[F_ZERO];
            default: take = 1'b1;
        endcase
        // Booth step: add/subtract, then arithmetic shift of {a, q}
        if (mq_reg[0] && !qm1_reg)
        begin
            bsum = ma_reg - mm_reg;
        end
        else if (!mq_reg[0] && qm1_reg)
        begin
            bsum = ma_reg + mm_reg;
        end
        else
        begin
            bsum = ma_reg;
        end
        ma_next    = {bsum[7], bsum[7:1]};
        mq_next    = {bsum[0], mq_reg[7:1]};
        mul_r      = {2'b00, ma_next, mq_next};
        io_buf_hit = (opw_reg >= IO_BUF_LO) && (opw_reg <= IO_BUF_HI);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            pc_reg        <= '0;
            mar_reg       <= '0;
            opw_reg       <= '0;
            acc_reg       <= '0;
            mbr_reg       <= '0;
            iobr_reg      <= '0;
            bus_latch_reg <= '0;
            flags_reg     <= '0;
            op_reg        <= '0;
            halted_reg    <= 1'b0;
            status_reg    <= ST_LOADED;
            dw_reg        <= 1'b0;
            dv_reg        <= '0;
            ma_reg        <= '0;
            mq_reg        <= '0;
            mm_reg        <= '0;
            qm1_reg       <= 1'b0;
            mcnt_reg      <= '0;
            for (int i = 0; i < IO_DEPTH; i++)
            begin
                io_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                dw_reg <= 1'b0;
                dv_reg <= '0;
                if (!in_command)
                begin
                    status_reg <= ST_LOADED;
                end
                else if (halted_reg)
                begin
                    status_reg <= ST_IGNORED;
                end
                else
                begin
                    status_reg <= ST_EXEC;
                end
            end
            if (cmd.fetch)
            begin
                pc_reg <= pc_reg + 16'd1;
            end
            if (cmd.cap_op)
            begin
                op_reg <= rdata_reg;
            end
            if (cmd.cap_lo)
            begin
                opw_reg[7:0] <= rdata_reg;
            end
            if (cmd.cap_hi)
            begin
                opw_reg[15:8] <= rdata_reg;
            end
            if (cmd.mem_done)
            begin
                bus_latch_reg <= rdata_reg;
                mbr_reg       <= rdata_reg;
            end
            if (cmd.mul_step)
            begin
                ma_reg   <= ma_next;
                mq_reg   <= mq_next;
                qm1_reg  <= mq_reg[0];
                mcnt_reg <= mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd7)
                begin
                    acc_reg   <= mul_r;
                    flags_reg <= flags_of(mul_r);
                end
            end
            if (cmd.exec)
            begin
                unique case (op_reg) inside
                    OP_EOP:
                    begin
                        halted_reg <= 1'b1;
                        status_reg <= ST_END;
                    end
                    OP_BR, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE:
                    begin
                        flags_reg <= cmp_f;
                        if (take)
                        begin
                            pc_reg <= opw_reg;
                        end
                    end
                    OP_WB:
                    begin
                        mbr_reg       <= opw_reg[7:0];
                        bus_latch_reg <= opw_reg[7:0];
                    end
                    OP_WIB:
                    begin
                        mbr_reg  <= opw_reg[7:0];
                        iobr_reg <= opw_reg[7:0];
                    end
                    OP_RM:
                    begin
                        mar_reg <= opw_reg;
                    end
                    OP_WM:
                    begin
                        mar_reg       <= opw_reg;
                        bus_latch_reg <= mbr_reg;
                    end
                    OP_RIO:
                    begin
                        mar_reg <= opw_reg;
                        if (io_buf_hit)
                        begin
                            bus_latch_reg <= io_reg[opw_reg[IO_AW-1:0]];
                            mbr_reg       <= io_reg[opw_reg[IO_AW-1:0]];
                        end
                        else
                        begin
                            mbr_reg <= bus_latch_reg;
                        end
                    end
                    OP_WIO:
                    begin
                        mar_reg       <= opw_reg;
                        bus_latch_reg <= mbr_reg;
                        if (opw_reg <= IO_LATCH_TOP)
                        begin
                            io_reg[opw_reg[IO_AW-1:0]] <= mbr_reg;
                            if (opw_reg == 16'd0)
                            begin
                                dw_reg <= 1'b1;
                                dv_reg <= mbr_reg;
                            end
                            if (opw_reg == 16'd1)
                            begin
                                io_reg[IO_MIRROR] <= bit_rev(mbr_reg);
                            end
                        end
                    end
                    OP_WACC:
                    begin
                        acc_reg <= {10'd0, mbr_reg};
                    end
                    OP_RACC:
                    begin
                        mbr_reg <= acc_reg[7:0];
                    end
                    OP_SWAP:
                    begin
                        mbr_reg  <= iobr_reg;
                        iobr_reg <= mbr_reg;
                    end
                    OP_MUL:
                    begin
                        ma_reg   <= '0;
                        mq_reg   <= bus_latch_reg;
                        mm_reg   <= acc_reg[7:0];
                        qm1_reg  <= 1'b0;
                        mcnt_reg <= '0;
                    end
                    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOT, OP_SHL, OP_SHR:
                    begin
                        acc_reg   <= alu_r;
                        flags_reg <= flags_of(alu_r);
                    end
                    default:
                    begin
                        halted_reg <= 1'b1;
                        status_reg <= ST_BADOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= {3'd0, dv_reg, dw_reg, mbr_reg, flags_reg, acc_reg[16:0],
                        pc_reg, status_reg};
        end
    end

    assign out_data = out_reg;

    always_comb
    begin
        sts.fetch_data = rdata_reg;
        sts.op         = op_reg;
        sts.halted     = halted_reg;
        sts.mul_last   = (mcnt_reg == 3'd7);
        sts.clr_last   = (clr_addr_reg == AW'(MEM_DEPTH - 1));
    end

endmodule

// ===== sv/acpu_ctrl.sv =====
// acpu_ctrl: sequencer of the accumulator processor - memory clearing sweep,
// instruction fetch, execute, multiply loop and result handshake.
// Depends on acpu_pkg.
module acpu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           in_command,
    output logic           out_valid,
    input  logic           out_ready,
    input  acpu_pkg::sts_t sts,
    output acpu_pkg::cmd_t cmd
);
    import acpu_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_F0   = 4'd2;
    localparam logic [3:0] S_F1   = 4'd3;
    localparam logic [3:0] S_W1   = 4'd4;
    localparam logic [3:0] S_W2   = 4'd5;
    localparam logic [3:0] S_B1   = 4'd6;
    localparam logic [3:0] S_EXEC = 4'd7;
    localparam logic [3:0] S_MEM  = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_RESP = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_command && !sts.halted) ? S_F0 : S_RESP;
                end
            end
            S_F0:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_F1;
            end
            S_F1:
            begin
                cmd.cap_op = 1'b1;
                unique case (sts.fetch_data) inside
                    OP_WM, OP_RM, OP_WIO, OP_RIO, OP_BR, OP_BRLT, OP_BRGT, OP_BRNE,
                    OP_BRE:
                    begin
                        cmd.fetch  = 1'b1;
                        state_next = S_W1;
                    end
                    OP_WB, OP_WIB:
                    begin
                        cmd.fetch  = 1'b1;
                        state_next = S_B1;
                    end
                    default:
                    begin
                        state_next = S_EXEC;
                    end
                endcase
            end
            S_W1:
            begin
                cmd.cap_lo = 1'b1;
                cmd.fetch  = 1'b1;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_EXEC;
            end
            S_B1:
            begin
                cmd.cap_lo = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.op == OP_RM)
                begin
                    state_next = S_MEM;
                end
                else if (sts.op == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_MEM:
            begin
                cmd.mem_done = 1'b1;
                state_next   = S_RESP;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/accumulator_cpu_8bit.sv =====
// accumulator_cpu_8bit: top level of the 8-bit accumulator processor.
// Depends on acpu_pkg, acpu_ctrl and acpu_dp.
//
//  channel   direction  contents
//  s_axis    in         one command: load a program byte or run one instruction
//  m_axis    out        one result per command: status and register snapshot
//
// After reset the main memory is swept to zero, one byte a cycle, with
// s_axis_tready low. A load or a halted step goes straight to the result; an
// instruction fetches its opcode and operand bytes through the single memory
// port (one byte per cycle), executes, then RM reads memory and MUL runs the
// eight Booth steps before the result. A new command is taken while the last
// result still waits; its result stalls until m_axis frees.
module accumulator_cpu_8bit #(
    parameter int MEM_DEPTH = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] command, [11:1] load_address, [19:12] load_byte, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [18:3] program_counter, [35:19] accumulator,
    // [43:36] flag_bits, [51:44] buffer_register, [52] display_write,
    // [60:53] display_value, [63:61] zero
    output logic [63:0] m_axis_tdata
);
    import acpu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    acpu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tdata[0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    acpu_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_command      (s_axis_tdata[0]),
        .in_load_address (s_axis_tdata[11:1]),
        .in_load_byte    (s_axis_tdata[19:12]),
        .out_data        (m_axis_tdata)
    );

endmodule

// ===== sv/acpu_chk.sv =====
// acpu_chk: port-level checks on the accumulator processor, bound to the top.
// Depends on accumulator_cpu_8bit ports only.
module acpu_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("status code out of range");

    a_disp: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[52] |-> m_axis_tdata[60:53] == 8'd0)
        else $error("display value without display transfer");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == 3'd0 || m_axis_tdata[2:0] == 3'd4)
        |-> !m_axis_tdata[52])
        else $error("display written by load or ignored command");

endmodule

bind accumulator_cpu_8bit acpu_chk u_acpu_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/accumulator_cpu_8bit_tb.sv =====
// accumulator_cpu_8bit_tb: self-checking bench for the accumulator processor.
// Writes small programs into memory, steps them and compares every result with
// an in-bench model of the processor. Depends on acpu_pkg and accumulator_cpu_8bit.
`timescale 1ns / 1ps

module accumulator_cpu_8bit_tb;
    import acpu_pkg::*;

    localparam int          MEM_DEPTH   = 2048;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [7:0]  OP_UNDEF    = 8'h1C;
    localparam bit          CMD_LOAD    = 1'b0;
    localparam bit          CMD_STEP    = 1'b1;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pc;
        logic [16:0] acc;
        logic [7:0]  flags;
        logic [7:0]  mbr;
        logic        dw;
        logic [7:0]  dv;
    } step_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    accumulator_cpu_8bit #(.MEM_DEPTH(MEM_DEPTH)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic [23:0]  cmd_queue[$];
    step_result_t result_queue[$];
    int           error_count = 0;
    int           cycle_count = 0;

    // processor model state
    logic [15:0] cpu_pc;
    int          cpu_acc;
    logic [7:0]  cpu_mbr;
    logic [15:0] cpu_mar;
    logic [7:0]  cpu_iobr;
    logic [7:0]  cpu_bus;
    logic [7:0]  cpu_flags;
    bit          cpu_halted;
    logic [7:0]  cpu_mem[MEM_DEPTH];
    logic [7:0]  cpu_io[32];

    logic [7:0] alu_ops[9] = '{OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT, OP_XOR,
                               OP_SHL, OP_SHR};
    logic [7:0] all_ops[23] = '{OP_WM, OP_RM, OP_WIO, OP_RIO, OP_WB, OP_WIB, OP_WACC,
                                OP_RACC, OP_SWAP, OP_BR, OP_BRLT, OP_BRGT, OP_BRNE,
                                OP_BRE, OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT,
                                OP_XOR, OP_SHL, OP_SHR};

    function automatic logic [7:0] flags_for(int r);
        logic [7:0] f;
        f          = 8'd0;
        f[F_ZERO]  = (r[7:0] == 8'd0);
        f[F_SIGN]  = r[7];
        f[F_CARRY] = (r > 255);
        f[F_OVER]  = r[7] && (r < 0);
        return f;
    endfunction

    function automatic logic [15:0] booth_product(logic [7:0] m, logic [7:0] q);
        logic [7:0] a;
        logic       qm1;
        a   = 8'd0;
        qm1 = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (q[0] && !qm1)
                a = a - m;
            else if (!q[0] && qm1)
                a = a + m;
            qm1 = q[0];
            q   = {a[0], q[7:1]};
            a   = {a[7], a[7:1]};   // arithmetic shift
        end
        return {a, q};
    endfunction

    function automatic logic [7:0] next_byte();
        logic [7:0] b;
        b      = cpu_mem[cpu_pc % MEM_DEPTH];
        cpu_pc = cpu_pc + 16'd1;
        return b;
    endfunction

    // Advance the model by one command and queue the command and its result.
    task automatic issue(bit cmd, logic [10:0] addr, logic [7:0] data);
        step_result_t res;
        logic [7:0]   op;
        logic [7:0]   lo;
        int           op1;
        int           r;
        bit           take;
        res = '0;
        res.status = ST_EXEC;
        if (cmd == CMD_LOAD)
        begin
            cpu_mem[addr % MEM_DEPTH] = data;
            res.status = ST_LOADED;
        end
        else if (cpu_halted)
            res.status = ST_IGNORED;
        else
        begin
            op  = next_byte();
            op1 = cpu_acc & 255;
            case (op) inside
                OP_EOP:
                begin
                    cpu_halted = 1'b1;
                    res.status = ST_END;
                end
                OP_BR, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE:
                begin
                    lo = next_byte();
                    r = {next_byte(), lo};
                    cpu_flags = flags_for(cpu_acc - int'(cpu_mbr));
                    case (op)
                        OP_BRE:  take = cpu_flags[F_ZERO];
                        OP_BRNE: take = !cpu_flags[F_ZERO];
                        OP_BRGT: take = !cpu_flags[F_ZERO] && !cpu_flags[F_SIGN];
                        OP_BRLT: take = cpu_flags[F_SIGN] && !cpu_flags[F_ZERO];
                        default: take = 1'b1;
                    endcase
                    if (take)
                        cpu_pc = r[15:0];
                end
                OP_WB:
                begin
                    cpu_mbr = next_byte();
                    cpu_bus = cpu_mbr;
                end
                OP_WIB:
                begin
                    cpu_mbr  = next_byte();
                    cpu_iobr = cpu_mbr;
                end
                OP_RM, OP_WM, OP_RIO, OP_WIO:
                begin
                    lo      = next_byte();
                    cpu_mar = {next_byte(), lo};
                    if (op == OP_RM)
                    begin
                        cpu_bus = cpu_mem[cpu_mar % MEM_DEPTH];
                        cpu_mbr = cpu_bus;
                    end
                    else if (op == OP_WM)
                    begin
                        cpu_bus = cpu_mbr;
                        cpu_mem[cpu_mar % MEM_DEPTH] = cpu_bus;
                    end
                    else if (op == OP_RIO)
                    begin
                        if (cpu_mar >= IO_BUF_LO && cpu_mar <= IO_BUF_HI)
                            cpu_bus = cpu_io[cpu_mar[4:0]];
                        cpu_mbr = cpu_bus;
                    end
                    else
                    begin
                        cpu_bus = cpu_mbr;
                        if (cpu_mar <= IO_LATCH_TOP)
                        begin
                            cpu_io[cpu_mar[4:0]] = cpu_bus;
                            if (cpu_mar == 16'd0)
                            begin
                                res.dw = 1'b1;
                                res.dv = cpu_bus;
                            end
                            // latch one is mirrored bit-reversed into the top entry
                            if (cpu_mar == 16'd1)
                                cpu_io[31] = {<<{cpu_io[1]}};
                        end
                    end
                end
                OP_WACC: cpu_acc = cpu_mbr;
                OP_RACC: cpu_mbr = cpu_acc[7:0];
                OP_SWAP:
                begin
                    lo       = cpu_mbr;
                    cpu_mbr  = cpu_iobr;
                    cpu_iobr = lo;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_NOT, OP_XOR, OP_SHL, OP_SHR:
                begin
                    case (op)
                        OP_ADD:  r = op1 + cpu_bus;
                        OP_SUB:  r = op1 - cpu_bus;
                        OP_MUL:  r = booth_product(op1[7:0], cpu_bus);
                        OP_AND:  r = op1 & cpu_bus;
                        OP_OR:   r = op1 | cpu_bus;
                        OP_NOT:  r = -1 - op1;
                        OP_XOR:  r = op1 ^ cpu_bus;
                        OP_SHL:  r = op1 * 2;
                        default: r = op1 >> 1;
                    endcase
                    cpu_acc   = r;
                    cpu_flags = flags_for(r);
                end
                default:
                begin
                    cpu_halted = 1'b1;
                    res.status = ST_BADOP;
                end
            endcase
        end
        res.pc    = cpu_pc;
        res.acc   = cpu_acc[16:0];
        res.flags = cpu_flags;
        res.mbr   = cpu_mbr;
        result_queue.push_back(res);
        cmd_queue.push_back({4'd0, data, addr, cmd});
    endtask

    // Write an instruction at the current pc, then step it.
    task automatic run_instr(logic [7:0] op, logic [15:0] operand);
        int nbytes;
        case (op) inside
            OP_WM, OP_RM, OP_WIO, OP_RIO, OP_BR, OP_BRLT, OP_BRGT, OP_BRNE, OP_BRE:
                nbytes = 3;
            OP_WB, OP_WIB:
                nbytes = 2;
            default:
                nbytes = 1;
        endcase
        issue(CMD_LOAD, 11'((cpu_pc) % MEM_DEPTH), op);
        if (nbytes > 1)
            issue(CMD_LOAD, 11'((cpu_pc + 1) % MEM_DEPTH), operand[7:0]);
        if (nbytes > 2)
            issue(CMD_LOAD, 11'((cpu_pc + 2) % MEM_DEPTH), operand[15:8]);
        issue(CMD_STEP, 11'($urandom), 8'($urandom));
    endtask

    task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
            error_count++;
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid && s_axis_tready)
                void'(cmd_queue.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cmd_queue[0];
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(40);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern drawn at random from four modes
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (cycle_count % 64 == 0)
                stall_mode = $urandom_range(3);
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(1));
                2:       m_axis_tready <= (cycle_count % 5 == 0);
                default: m_axis_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        step_result_t expv;
        step_result_t actv;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            actv = {m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[35:19],
                    m_axis_tdata[43:36], m_axis_tdata[51:44], m_axis_tdata[52],
                    m_axis_tdata[60:53]};
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %0h", $time, actv);
                error_count++;
            end
            else
            begin
                expv = result_queue.pop_front();
                check_field("status", expv.status, actv.status);
                check_field("program_counter", expv.pc, actv.pc);
                check_field("accumulator", expv.acc, actv.acc);
                check_field("flag_bits", expv.flags, actv.flags);
                check_field("buffer_register", expv.mbr, actv.mbr);
                check_field("display_write", expv.dw, actv.dw);
                check_field("display_value", expv.dv, actv.dv);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("accumulator_cpu_8bit_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int pick;
        cpu_pc = '0; cpu_acc = 0; cpu_mbr = '0; cpu_mar = '0; cpu_iobr = '0;
        cpu_bus = '0; cpu_flags = '0; cpu_halted = 1'b0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
        foreach (cpu_io[i]) cpu_io[i] = '0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: operand extremes, each operation, I/O corners, wraps
        run_instr(OP_WB, 16'h00FF);
        run_instr(OP_WACC, 0);
        run_instr(OP_ADD, 0);
        run_instr(OP_NOT, 0);
        run_instr(OP_SUB, 0);
        run_instr(OP_MUL, 0);
        run_instr(OP_WB, 16'h0080);
        run_instr(OP_WACC, 0);
        run_instr(OP_MUL, 0);
        run_instr(OP_SHL, 0);
        run_instr(OP_SHR, 0);
        run_instr(OP_XOR, 0);
        run_instr(OP_OR, 0);
        run_instr(OP_AND, 0);
        run_instr(OP_RACC, 0);
        run_instr(OP_WIB, 16'h005A);
        run_instr(OP_SWAP, 0);
        run_instr(OP_WIO, 16'h0000);
        run_instr(OP_WIO, 16'h0001);
        run_instr(OP_RIO, 16'h001F);
        run_instr(OP_RIO, 16'h0020);
        run_instr(OP_WIO, 16'h0010);
        run_instr(OP_WM, 16'hFFFF);
        run_instr(OP_RM, 16'hFFFF);
        run_instr(OP_BRE, 16'h0100);
        run_instr(OP_BRNE, 16'h0200);
        run_instr(OP_BRLT, 16'h0300);
        run_instr(OP_BRGT, 16'h0400);
        run_instr(OP_BR, 16'hFFFE);
        run_instr(OP_WB, 16'h00C3);     // pc wraps past 0xFFFF

        // random programs with some stray loads
        while (cmd_queue.size() < 1150)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                issue(CMD_LOAD, 11'($urandom), 8'($urandom));
            else if (pick <= 3)
                run_instr(alu_ops[$urandom_range(8)], 0);
            else if (pick == 4)
                run_instr(($urandom_range(1) == 0) ? OP_WIO : OP_RIO,
                          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(33)));
            else if (pick == 5)
                run_instr(($urandom_range(1) == 0) ? OP_BR + 8'($urandom_range(4)) : OP_WACC,
                          ($urandom_range(7) == 0) ? 16'hFFFD + 16'($urandom_range(2))
                                                   : 16'($urandom));
            else
                run_instr(all_ops[$urandom_range(22)], 16'($urandom));
        end

        // halt, then a step, a load and another step while halted
        run_instr(($urandom_range(1) == 0) ? OP_EOP : OP_UNDEF, 0);
        issue(CMD_STEP, 11'($urandom), 8'($urandom));
        issue(CMD_LOAD, 11'h7FF, 8'hA5);
        issue(CMD_STEP, 11'h000, 8'h00);

        while (cmd_queue.size() > 0 || result_queue.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("accumulator_cpu_8bit_tb: clean");
        else
            $display("accumulator_cpu_8bit_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/acpu_pkg.sv
sv/acpu_dp.sv
sv/acpu_ctrl.sv
sv/accumulator_cpu_8bit.sv
sv/acpu_chk.sv
sim/accumulator_cpu_8bit_tb.sv
